### rtl/lts_pkg.sv
`default_nettype none
package lts_pkg;

	// token kinds
	localparam logic [3:0] K_NUMBER  = 4'd0;
	localparam logic [3:0] K_STRING  = 4'd1;
	localparam logic [3:0] K_SYMBOL  = 4'd2;
	localparam logic [3:0] K_LPAREN  = 4'd3;
	localparam logic [3:0] K_RPAREN  = 4'd4;
	localparam logic [3:0] K_QUOTE   = 4'd5;
	localparam logic [3:0] K_EOF     = 4'd6;
	localparam logic [3:0] K_BADCHAR = 4'd7;
	localparam logic [3:0] K_UNTERM  = 4'd8;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	// defaults for the top-level parameters
	localparam int DEF_OFFSET_BITS = 32;
	localparam int DEF_LINE_BITS   = 32;

	// entries in the token queue
	localparam int QUEUE_DEPTH = 4;

	// slots of one queue entry: pending token, dot error, own token or EOF
	localparam int SLOTS = 3;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] start;
		logic [31:0] length;
	} token_t;

	// all tokens caused by one input item; they share the line number
	typedef struct packed {
		logic [SLOTS-1:0]         valid;
		logic [31:0]              line;
		token_t [SLOTS-1:0]       tok;
	} entry_t;

endpackage
`default_nettype wire

### rtl/lts_front.sv
`default_nettype none
module lts_front
	import lts_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int LINE_BITS   = DEF_LINE_BITS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] source_byte,
	input  wire logic       end_of_source,
	output entry_t          entry
);

	typedef enum logic [2:0] {
		M_IDLE, M_COMMENT, M_SYMBOL, M_NUMBER, M_NUMDOT, M_FRACTION, M_STRING, M_DONE
	} mode_t;

	mode_t                  mode_q, nx_mode;
	logic [OFFSET_BITS-1:0] rp_q, nx_rp;
	logic [OFFSET_BITS-1:0] tb_q, nx_tb;
	logic [LINE_BITS-1:0]   line_q, nx_line;

	logic [OFFSET_BITS-1:0] rp_inc, tok_len, dot_len, str_len;
	logic [LINE_BITS-1:0]   line_inc;
	logic                   is_dig, is_alph, is_end;

	// outcome of scanning the byte between tokens
	mode_t                  idle_mode;
	logic                   idle_tb, idle_nl, idle_emit;
	logic [3:0]             idle_kind;
	logic                   idle_len1;

	// tokens released by leaving a symbol or number
	token_t                 fl_t0, fl_t1;
	logic                   fl_v0, fl_v1;

	logic                   do_flush, do_idle;

	function automatic logic [31:0] sat32(input logic [63:0] v);
		return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	assign is_end   = end_of_source || (source_byte == CH_NUL);
	assign is_dig   = source_byte inside {[8'h30:8'h39]};
	assign is_alph  = source_byte inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER};
	assign rp_inc   = (rp_q == '1) ? rp_q : rp_q + OFFSET_BITS'(1);
	assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
	assign tok_len  = rp_q - tb_q;
	assign dot_len  = (tok_len == '0) ? '0 : tok_len - OFFSET_BITS'(1);
	assign str_len  = rp_inc - tb_q;

	// byte seen between tokens
	always_comb begin
		idle_mode = M_IDLE;
		idle_tb   = 1'b0;
		idle_nl   = 1'b0;
		idle_emit = 1'b0;
		idle_kind = K_BADCHAR;
		idle_len1 = 1'b0;
		case (source_byte)
			CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF: begin
			end
			CH_NL: idle_nl = 1'b1;
			CH_SEMI: idle_mode = M_COMMENT;
			CH_LPAREN: begin
				idle_emit = 1'b1;
				idle_kind = K_LPAREN;
				idle_len1 = 1'b1;
			end
			CH_RPAREN: begin
				idle_emit = 1'b1;
				idle_kind = K_RPAREN;
				idle_len1 = 1'b1;
			end
			CH_QUOTE: begin
				idle_emit = 1'b1;
				idle_kind = K_QUOTE;
				idle_len1 = 1'b1;
			end
			CH_DQUOTE: begin
				idle_tb   = 1'b1;
				idle_mode = M_STRING;
			end
			default: begin
				if (is_alph) begin
					idle_tb   = 1'b1;
					idle_mode = M_SYMBOL;
				end else if (is_dig) begin
					idle_tb   = 1'b1;
					idle_mode = M_NUMBER;
				end else begin
					idle_emit = 1'b1;
				end
			end
		endcase
	end

	// pending token; a trailing dot splits off as an error
	always_comb begin
		fl_v0        = 1'b0;
		fl_v1        = 1'b0;
		fl_t0.kind   = K_NUMBER;
		fl_t0.start  = sat32(64'(tb_q));
		fl_t0.length = sat32(64'(tok_len));
		fl_t1.kind   = K_BADCHAR;
		fl_t1.start  = sat32(64'(rp_q - OFFSET_BITS'(1)));
		fl_t1.length = '0;
		case (mode_q)
			M_SYMBOL: begin
				fl_v0      = 1'b1;
				fl_t0.kind = K_SYMBOL;
			end
			M_NUMBER, M_FRACTION: fl_v0 = 1'b1;
			M_NUMDOT: begin
				fl_v0        = 1'b1;
				fl_v1        = 1'b1;
				fl_t0.length = sat32(64'(dot_len));
			end
			default: begin
			end
		endcase
	end

	// next state and the queue entry for this item
	always_comb begin
		nx_mode  = mode_q;
		nx_rp    = rp_q;
		nx_tb    = tb_q;
		nx_line  = line_q;
		do_flush = 1'b0;
		do_idle  = 1'b0;
		entry.valid  = '0;
		entry.line   = sat32(64'(line_q));
		entry.tok[0] = fl_t0;
		entry.tok[1] = fl_t1;
		entry.tok[2].kind   = K_EOF;
		entry.tok[2].start  = sat32(64'(rp_q));
		entry.tok[2].length = '0;

		if (mode_q == M_DONE) begin
			entry.valid[2] = 1'b1;
		end else if (is_end) begin
			if (mode_q == M_STRING) begin
				entry.valid[0]      = 1'b1;
				entry.tok[0].kind   = K_UNTERM;
				entry.tok[0].start  = sat32(64'(tb_q));
				entry.tok[0].length = '0;
			end else begin
				do_flush = 1'b1;
			end
			entry.valid[2] = 1'b1;
			nx_mode        = M_DONE;
		end else begin
			case (mode_q)
				M_COMMENT: begin
					if (source_byte == CH_NL) do_idle = 1'b1;
					else nx_rp = rp_inc;
				end
				M_SYMBOL: begin
					if (is_alph || is_dig) nx_rp = rp_inc;
					else do_flush = 1'b1;
				end
				M_NUMBER: begin
					if (is_dig) begin
						nx_rp = rp_inc;
					end else if (source_byte == CH_DOT) begin
						nx_rp   = rp_inc;
						nx_mode = M_NUMDOT;
					end else begin
						do_flush = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (is_dig) begin
						nx_rp   = rp_inc;
						nx_mode = M_FRACTION;
					end else begin
						do_flush = 1'b1;
					end
				end
				M_FRACTION: begin
					if (is_dig) nx_rp = rp_inc;
					else do_flush = 1'b1;
				end
				M_STRING: begin
					nx_rp = rp_inc;
					if (source_byte == CH_DQUOTE) begin
						entry.valid[2]      = 1'b1;
						entry.tok[2].kind   = K_STRING;
						entry.tok[2].start  = sat32(64'(tb_q));
						entry.tok[2].length = sat32(64'(str_len));
						nx_mode             = M_IDLE;
					end else if (source_byte == CH_NL) begin
						nx_line = line_inc;
					end
				end
				default: do_idle = 1'b1;
			endcase
			// a byte that ends a symbol or number is scanned anew
			if (do_flush) do_idle = 1'b1;
		end

		if (do_flush) begin
			entry.valid[0] = fl_v0;
			entry.valid[1] = fl_v1;
		end
		if (do_idle) begin
			nx_mode = idle_mode;
			nx_rp   = rp_inc;
			if (idle_tb) nx_tb = rp_q;
			if (idle_nl) nx_line = line_inc;
			if (idle_emit) begin
				entry.valid[2]      = 1'b1;
				entry.tok[2].kind   = idle_kind;
				entry.tok[2].length = idle_len1 ? 32'd1 : 32'd0;
			end
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			rp_q   <= '0;
			tb_q   <= '0;
			line_q <= LINE_BITS'(1);
		end else if (accept) begin
			mode_q <= nx_mode;
			rp_q   <= nx_rp;
			tb_q   <= nx_tb;
			line_q <= nx_line;
		end
	end

endmodule
`default_nettype wire

### rtl/lts_queue.sv
`default_nettype none
module lts_queue
	import lts_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t wr_data,
	output logic        full,
	input  wire logic   pop,
	output logic        empty,
	output entry_t      rd_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

### rtl/lts_back.sv
`default_nettype none
module lts_back
	import lts_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          empty,
	input  wire entry_t        head,
	output logic               pop,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [103:0]       m_axis_tdata,
	output logic               m_axis_tlast
);

	logic [1:0]       sel_q;
	logic [SLOTS-1:0] rem;
	logic [1:0]       first;
	logic             is_last;
	logic             load;
	token_t           tok_q;
	logic [31:0]      line_q;
	logic             last_q;

	// slots of the head entry not yet sent
	always_comb begin
		case (sel_q)
			2'd0:    rem = head.valid;
			2'd1:    rem = head.valid & 3'b110;
			default: rem = head.valid & 3'b100;
		endcase
		if (rem[0]) begin
			first   = 2'd0;
			is_last = (rem[2:1] == 2'b00);
		end else if (rem[1]) begin
			first   = 2'd1;
			is_last = !rem[2];
		end else begin
			first   = 2'd2;
			is_last = 1'b1;
		end
	end

	assign load = !empty && (!m_axis_tvalid || m_axis_tready);
	assign pop  = load && is_last;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
			sel_q         <= 2'd0;
		end else begin
			if (load) begin
				m_axis_tvalid <= 1'b1;
				sel_q         <= is_last ? 2'd0 : first + 2'd1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= head.tok[first];
			line_q <= head.line;
			last_q <= is_last;
		end
	end

	assign m_axis_tdata = {4'b0000, line_q, tok_q.length, tok_q.start, tok_q.kind};
	assign m_axis_tlast = last_q;

endmodule
`default_nettype wire

### rtl/lisp_token_scanner_core.sv
`default_nettype none
// Lisp token scanner. Source bytes enter one per item on the s_axis side
// (tuser marks end of source; a zero byte does too) and tokens leave on the
// m_axis side, tlast on the last token caused by an input byte. The scanner
// takes one byte per clock; a byte that yields tokens puts one entry into a
// four-entry token queue, and the output side sends one token per clock, so
// input stalls only while bursts of tokens (up to three per byte) back up the
// queue or the sink holds tready low. The first token of a byte is registered
// in the token queue and then in the output register. After end of source
// every further byte yields one more EOF token until reset.
module lisp_token_scanner_core
	import lts_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int LINE_BITS   = DEF_LINE_BITS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [7:0] source_byte
	input  wire logic         s_axis_tuser,  // [0] end_of_source
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [3:0] token_kind, [35:4] token_start, [67:36] token_length,
	// [99:68] token_line, [103:100] zero
	output logic [103:0]      m_axis_tdata,
	output logic              m_axis_tlast   // last_of_run
);

	entry_t entry, head;
	logic   accept, full, empty, pop;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	lts_front #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS  (LINE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.source_byte  (s_axis_tdata),
		.end_of_source(s_axis_tuser),
		.entry        (entry)
	);

	// items that yield no token never enter the queue
	lts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && (entry.valid != '0)),
		.wr_data(entry),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_data(head)
	);

	lts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
`default_nettype wire

### verif/lexer_token_checker.sv
// Watches both streams of the scanner, predicts the tokens of every accepted
// source byte and compares each token leaving the block with the oldest one
// predicted.
module lexer_token_checker
	import lts_pkg::*;
#(
	parameter int OFFSET_BITS = DEF_OFFSET_BITS,
	parameter int LINE_BITS   = DEF_LINE_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] source_byte
	input  logic         s_axis_tuser,   // [0] end_of_source
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [3:0] kind, [35:4] start, [67:36] length, [99:68] line, [103:100] zero
	input  logic [103:0] m_axis_tdata,
	input  logic         m_axis_tlast,
	output int           fail_count,
	output int           tokens_pending,
	output int           tokens_checked,
	output logic [8:0]   kinds_seen
);

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_COMMENT,
		SCAN_SYMBOL,
		SCAN_NUMBER,
		SCAN_NUMDOT,
		SCAN_FRACTION,
		SCAN_STRING,
		SCAN_DONE
	} scan_state_t;

	typedef struct {
		logic [3:0]  kind;
		logic [31:0] start;
		logic [31:0] length;
		logic [31:0] line;
		logic        last;
	} token_exp_t;

	localparam logic [63:0] POS_MAX  = (OFFSET_BITS >= 64) ? '1 : (64'd1 << OFFSET_BITS) - 1;
	localparam logic [63:0] LINE_MAX = (LINE_BITS >= 64) ? '1 : (64'd1 << LINE_BITS) - 1;

	// lexer state as seen by the predictor
	scan_state_t mode = SCAN_IDLE;
	logic [63:0] pos = 64'd0;
	logic [63:0] tok_at = 64'd0;
	logic [63:0] line_no = 64'd1;
	int          item_tokens;

	token_exp_t expected_tokens[$];

	initial kinds_seen = '0;

	function automatic logic [31:0] clip32(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [63:0] span_of(logic [63:0] from, logic [63:0] upto);
		return (upto >= from) ? upto - from : 64'd0;
	endfunction

	function automatic bit num_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit word_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
	endfunction

	task automatic bump_pos();
		if (pos < POS_MAX) pos++;
	endtask

	task automatic bump_line();
		if (line_no < LINE_MAX) line_no++;
	endtask

	// at most three tokens per byte; the line is the one reached so far
	task automatic add_token(logic [3:0] kind, logic [63:0] start, logic [63:0] len);
		token_exp_t t;
		if (item_tokens >= 3) return;
		t.kind   = kind;
		t.start  = clip32(start);
		t.length = clip32(len);
		t.line   = clip32(line_no);
		t.last   = 1'b0;
		expected_tokens.push_back(t);
		item_tokens++;
	endtask

	// close a symbol or number that is still open
	task automatic flush_token();
		logic [63:0] dot;
		case (mode)
			SCAN_SYMBOL: add_token(K_SYMBOL, tok_at, span_of(tok_at, pos));
			SCAN_NUMBER, SCAN_FRACTION: add_token(K_NUMBER, tok_at, span_of(tok_at, pos));
			SCAN_NUMDOT: begin
				// dot with no digit after it: number without the dot, then the dot
				dot = (pos > 0) ? pos - 1 : 64'd0;
				add_token(K_NUMBER, tok_at, span_of(tok_at, dot));
				add_token(K_BADCHAR, dot, 64'd0);
			end
			default: ;
		endcase
		mode = SCAN_IDLE;
	endtask

	// byte seen between tokens
	task automatic idle_byte(logic [7:0] c);
		case (c)
			CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF: bump_pos();
			CH_NL: begin
				bump_line();
				bump_pos();
			end
			CH_SEMI: begin
				mode = SCAN_COMMENT;
				bump_pos();
			end
			CH_LPAREN: begin
				add_token(K_LPAREN, pos, 64'd1);
				bump_pos();
			end
			CH_RPAREN: begin
				add_token(K_RPAREN, pos, 64'd1);
				bump_pos();
			end
			CH_QUOTE: begin
				add_token(K_QUOTE, pos, 64'd1);
				bump_pos();
			end
			CH_DQUOTE: begin
				tok_at = pos;
				mode = SCAN_STRING;
				bump_pos();
			end
			default: begin
				if (word_char(c) || num_char(c)) begin
					tok_at = pos;
					mode = word_char(c) ? SCAN_SYMBOL : SCAN_NUMBER;
				end else begin
					add_token(K_BADCHAR, pos, 64'd0);
				end
				bump_pos();
			end
		endcase
	endtask

	task automatic scan_char(logic [7:0] c);
		case (mode)
			SCAN_COMMENT: begin
				if (c == CH_NL) begin
					mode = SCAN_IDLE;
					idle_byte(c);
				end else begin
					bump_pos();
				end
				return;
			end
			SCAN_SYMBOL: begin
				if (word_char(c) || num_char(c)) begin
					bump_pos();
					return;
				end
			end
			SCAN_NUMBER: begin
				if (num_char(c)) begin
					bump_pos();
					return;
				end
				if (c == CH_DOT) begin
					mode = SCAN_NUMDOT;
					bump_pos();
					return;
				end
			end
			SCAN_NUMDOT: begin
				if (num_char(c)) begin
					mode = SCAN_FRACTION;
					bump_pos();
					return;
				end
			end
			SCAN_FRACTION: begin
				if (num_char(c)) begin
					bump_pos();
					return;
				end
			end
			SCAN_STRING: begin
				if (c == CH_DQUOTE) begin
					bump_pos();
					add_token(K_STRING, tok_at, span_of(tok_at, pos));
					mode = SCAN_IDLE;
				end else begin
					if (c == CH_NL) bump_line();
					bump_pos();
				end
				return;
			end
			default: begin
				idle_byte(c);
				return;
			end
		endcase
		flush_token();
		idle_byte(c);
	endtask

	// tokens caused by one source item
	task automatic predict_tokens(logic [7:0] c, logic eos);
		item_tokens = 0;
		if (mode == SCAN_DONE) begin
			add_token(K_EOF, pos, 64'd0);
		end else if (eos || c == CH_NUL) begin
			if (mode == SCAN_STRING) begin
				add_token(K_UNTERM, tok_at, 64'd0);
				mode = SCAN_IDLE;
			end else begin
				flush_token();
			end
			add_token(K_EOF, pos, 64'd0);
			mode = SCAN_DONE;
		end else begin
			scan_char(c);
		end
		if (item_tokens > 0) expected_tokens[expected_tokens.size() - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH token %0d %s: got 0x%0h, expected 0x%0h",
			tokens_checked, what, got, want);
		fail_count++;
	endtask

	// sample both streams at the rising edge
	always @(posedge clk) begin
		token_exp_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_tokens(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_tokens.size() == 0) begin
					report_mismatch("arrived with none expected, kind", {28'd0, m_axis_tdata[3:0]},
						32'd0);
				end else begin
					want = expected_tokens.pop_front();
					if (m_axis_tdata[3:0] !== want.kind)
						report_mismatch("kind", {28'd0, m_axis_tdata[3:0]}, {28'd0, want.kind});
					if (m_axis_tdata[35:4] !== want.start)
						report_mismatch("start", m_axis_tdata[35:4], want.start);
					if (m_axis_tdata[67:36] !== want.length)
						report_mismatch("length", m_axis_tdata[67:36], want.length);
					if (m_axis_tdata[99:68] !== want.line)
						report_mismatch("line", m_axis_tdata[99:68], want.line);
					if (m_axis_tlast !== want.last)
						report_mismatch("tlast", {31'd0, m_axis_tlast}, {31'd0, want.last});
					if (want.kind <= K_UNTERM) kinds_seen[want.kind] = 1'b1;
				end
				tokens_checked++;
			end
			tokens_pending = expected_tokens.size();
		end
	end

endmodule

### verif/tb_lisp_token_scanner_core.sv
// Drives source text into the scanner and gives the verdict; the checker
// beside the block predicts and compares every token.
module tb_lisp_token_scanner_core
	import lts_pkg::*;
();

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'd0;   // [7:0] source_byte
	logic         s_axis_tuser = 1'b0;   // [0] end_of_source
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// [3:0] kind, [35:4] start, [67:36] length, [99:68] line, [103:100] zero
	logic [103:0] m_axis_tdata;
	logic         m_axis_tlast;

	int         fail_count;
	int         tokens_pending;
	int         tokens_checked;
	logic [8:0] kinds_seen;

	// no idling on either side near the end of the run
	bit         calm = 1'b0;
	int         bytes_sent = 0;
	logic [7:0] source_text[$];

	lisp_token_scanner_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	lexer_token_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.fail_count     (fail_count),
		.tokens_pending (tokens_pending),
		.tokens_checked (tokens_checked),
		.kinds_seen     (kinds_seen)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

	// token sink: holds tready low in random stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = int'($urandom_range(1, 3)) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] letter_byte();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26) return 8'(8'h61 + r);
		if (r < 52) return 8'(8'h41 + (r - 26));
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] digit_byte();
		return 8'(8'h30 + $urandom_range(0, 9));
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) source_text.push_back(s[i]);
	endtask

	// one token, a comment, a layout byte or a noise byte
	task automatic add_random_fragment();
		int         pick;
		int         n;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			source_text.push_back(letter_byte());
			n = $urandom_range(0, 6);
			repeat (n)
				source_text.push_back(($urandom_range(0, 3) == 0) ? digit_byte() : letter_byte());
		end else if (pick < 36) begin
			n = $urandom_range(1, 4);
			repeat (n) source_text.push_back(digit_byte());
			if ($urandom_range(0, 2) == 0) begin
				source_text.push_back(CH_DOT);
				n = $urandom_range(0, 3);
				repeat (n) source_text.push_back(digit_byte());
			end
		end else if (pick < 50) begin
			case ($urandom_range(0, 2))
				0: source_text.push_back(CH_LPAREN);
				1: source_text.push_back(CH_RPAREN);
				default: source_text.push_back(CH_QUOTE);
			endcase
		end else if (pick < 58) begin
			source_text.push_back(CH_DQUOTE);
			n = $urandom_range(0, 6);
			repeat (n) begin
				c = 8'($urandom_range(8'h20, 8'h7E));
				if (c == CH_DQUOTE) c = CH_SP;
				if ($urandom_range(0, 7) == 0) c = CH_NL;
				source_text.push_back(c);
			end
			source_text.push_back(CH_DQUOTE);
		end else if (pick < 63) begin
			source_text.push_back(CH_SEMI);
			n = $urandom_range(0, 8);
			repeat (n) begin
				c = 8'($urandom_range(1, 255));
				if (c == CH_NL) c = CH_SP;
				source_text.push_back(c);
			end
			source_text.push_back(CH_NL);
		end else if (pick < 86) begin
			case ($urandom_range(0, 5))
				0: source_text.push_back(CH_SP);
				1: source_text.push_back(CH_TAB);
				2: source_text.push_back(CH_CR);
				3: source_text.push_back(CH_VT);
				4: source_text.push_back(CH_FF);
				default: source_text.push_back(CH_NL);
			endcase
		end else begin
			source_text.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	// present one item, with an optional idle burst before it
	task automatic send_byte(logic [7:0] c, logic eos);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tuser  <= eos;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	initial begin
		int ending;
		int directed_len;

		// directed text: parens, quote, symbol with underscore and digit,
		// fraction, number then dot with no digit, comment, string across a
		// newline, high byte, other layout characters
		push_text("(a_9 'x 1.5 3.)");
		push_text("\t;c\n");
		push_text("\"s\n\"");
		source_text.push_back(8'hFF);
		source_text.push_back(CH_VT);
		source_text.push_back(CH_FF);
		source_text.push_back(CH_CR);
		directed_len = source_text.size();

		while (source_text.size() < directed_len + 125) add_random_fragment();

		// what is left open when the source ends
		ending = $urandom_range(0, 3);
		case (ending)
			0: push_text("\"ab");
			1: push_text("7.");
			2: push_text("xy");
			default: ;
		endcase

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (source_text[i]) begin
			if (i >= source_text.size() - 25) calm = 1'b1;
			send_byte(source_text[i], 1'b0);
		end

		// end by zero byte or by end flag with any byte
		if (ending % 2 == 1) send_byte(CH_NUL, 1'b0);
		else send_byte(8'($urandom_range(0, 255)), 1'b1);

		// after the end, every item yields one more EOF
		repeat (5) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		s_axis_tvalid <= 1'b0;

		while (tokens_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Scanned %0d source items (ending style %0d), compared %0d tokens",
			bytes_sent, ending, tokens_checked);
		$display("Token kinds covered, one bit per kind from number up: %b", kinds_seen);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
